@@ rtl/assert_macros.svh @@
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define WFD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define WFD_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ rtl/wfd_pkg.sv @@
// Types, constants and functions of the log segment deframer.
package wfd_pkg;

   localparam int HOLD_LEN    = 16;
   localparam int HOLD_W      = $clog2(HOLD_LEN);
   localparam int RP_W        = HOLD_W + 1;
   localparam int MAGIC_LEN   = 12;
   localparam int CRC_LEN     = 4;
   localparam int MIN_BODY    = 25;
   localparam int SEQ_BYTES   = 8;
   localparam int OP_POS      = 8;
   localparam int ID_POS      = 9;
   localparam int DIM_POS     = 17;
   localparam int PREFIX_LEN  = 21;
   localparam int OPQ_DEPTH   = 4;
   localparam int OPQ_AW      = $clog2(OPQ_DEPTH);
   localparam int OUTQ_DEPTH  = 2;
   localparam int OUTQ_AW     = $clog2(OUTQ_DEPTH);

   localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      KIND_RECORD  = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_CORRUPT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      OP_FEED = 2'd0,
      OP_JOB  = 2'd1,
      OP_END  = 2'd2
   } op_kind_type;

   // One parser operation from the front to the back.
   typedef struct packed {
      op_kind_type kind;
      logic        clr;
      logic        last;
      logic [7:0]  data;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } op_push_type;

   typedef struct packed {
      kind_type    kind;
      logic [63:0] seq;
      logic [7:0]  rec_op;
      logic [63:0] id;
      logic [31:0] dim;
      logic [31:0] pay;
      logic        last;
   } result_type;

   // File header magic text, byte by byte.
   function automatic logic [7:0] magic_byte(input logic [HOLD_W-1:0] idx);
      logic [7:0] b;
      case (idx)
         4'd0:    b = 8'h70;
         4'd1:    b = 8'h6F;
         4'd2:    b = 8'h6D;
         4'd3:    b = 8'h61;
         4'd4:    b = 8'h69;
         4'd5:    b = 8'h2E;
         4'd6:    b = 8'h77;
         4'd7:    b = 8'h61;
         4'd8:    b = 8'h6C;
         4'd9:    b = 8'h2E;
         4'd10:   b = 8'h76;
         4'd11:   b = 8'h31;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // Reflected CRC32C update over one byte.
   function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] d);
      logic [31:0] c;
      c = crc ^ {24'd0, d};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ rtl/wfd_req_if.sv @@
// Input byte channel of the deframer.
interface wfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       segment_first;
   logic       segment_last;
   logic       job_last;

   modport source (output valid, data_byte, segment_first, segment_last, job_last,
                   input ready);
   modport sink   (input valid, data_byte, segment_first, segment_last, job_last,
                   output ready);
endinterface

@@ rtl/wfd_rsp_if.sv @@
// Result channel of the deframer.
interface wfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [63:0] sequence_res;
   logic [7:0]  record_op;
   logic [63:0] record_id;
   logic [31:0] dimension;
   logic [31:0] payload_bytes;
   logic        last;

   modport source (output valid, kind, sequence_res, record_op, record_id, dimension,
                   payload_bytes, last, input ready);
   modport sink   (input valid, kind, sequence_res, record_op, record_id, dimension,
                   payload_bytes, last, output ready);
endinterface

@@ rtl/wal_frame_deframer_crc32c.sv @@
// Log segment deframer with CRC32C frame check: top level.
//
// req_bus carries one segment byte per beat with segment start, segment end and
// job end marks; a beat is taken when valid and ready are both high. rsp_bus
// carries record, done and corruption results, last set on the final result of
// a beat. csr_we/csr_wdata load the start sequence, also the running sequence.
// Plain body bytes go in at one beat per cycle while the op queue has room.
// A beat with a segment or job mark, or the sixteenth header byte, is walked
// by the front sequencer at one op per cycle while the op queue has room,
// replaying up to 16 held bytes. A plain body byte's result is registered in
// the op queue, then the output queue; a marked beat's results follow its ops.
// Ops pass through a four-entry queue to the parser, whose results go to a
// two-entry output queue; a stalled receiver fills both queues, then ready
// drops. Synchronous reset empties the queues, clears the parser and the
// header hold state and sets the start and running sequence to zero.
module wal_frame_deframer_crc32c (
   input  logic        clock,
   input  logic        reset,
   wfd_req_if.sink     req_bus,
   wfd_rsp_if.source   rsp_bus,
   input  logic        csr_we,
   input  logic [63:0] csr_wdata
);
   import wfd_pkg::*;

   op_push_type push;
   op_type      head;
   logic        head_valid;
   logic        head_pop;
   logic        q_full;

   wfd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .push    (push),
      .q_full  (q_full)
   );

   wfd_opq u_opq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .head       (head),
      .head_valid (head_valid),
      .pop        (head_pop),
      .full       (q_full)
   );

   wfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op        (head),
      .op_valid  (head_valid),
      .op_pop    (head_pop),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_bus   (rsp_bus)
   );

endmodule

@@ rtl/wfd_front.sv @@
// Front sequencer: takes input beats, holds segment headers and issues parser ops.
`include "assert_macros.svh"
module wfd_front (
   input  logic                 clock,
   input  logic                 reset,
   wfd_req_if.sink              req_bus,
   output wfd_pkg::op_push_type push,
   input  logic                 q_full
);
   import wfd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_RUN    = 3'b010,
      ST_REPLAY = 3'b100
   } front_state_type;

   front_state_type   state_ff, state_in;
   logic              hdr_ff, hdr_in;
   logic [HOLD_W-1:0] fill_ff, fill_in;
   logic              match_ff, match_in;
   logic              pend_ff, pend_in;
   logic              t_first_ff, t_first_in;
   logic              t_byte_ff, t_byte_in;
   logic              t_end_ff, t_end_in;
   logic              t_job_ff, t_job_in;
   logic [RP_W-1:0]   rp_ff, rp_in;
   logic [RP_W-1:0]   lim_ff, lim_in;
   logic              clr_after_ff, clr_after_in;
   logic [7:0]        it_byte_ff;
   logic [7:0]        hold_ff [HOLD_LEN];

   logic       latch;
   logic       do_store;
   logic       slow;
   logic       fill_top;
   logic       m_new;
   logic [7:0] st_byte;

   assign st_byte  = (state_ff == ST_IDLE) ? req_bus.data_byte : it_byte_ff;
   assign fill_top = (fill_ff == HOLD_W'(HOLD_LEN - 1));
   assign slow     = req_bus.segment_first | req_bus.segment_last | req_bus.job_last |
                     (hdr_ff & fill_top);

   // Running magic match over the header bytes held so far
   always_comb begin
      m_new = (fill_ff == '0) ? 1'b1 : match_ff;
      if (fill_ff < HOLD_W'(MAGIC_LEN)) begin
         m_new = m_new & (st_byte == magic_byte(fill_ff));
      end
   end

   // Sequence the tasks of one beat
   always_comb begin
      state_in     = state_ff;
      hdr_in       = hdr_ff;
      fill_in      = fill_ff;
      match_in     = match_ff;
      pend_in      = pend_ff;
      t_first_in   = t_first_ff;
      t_byte_in    = t_byte_ff;
      t_end_in     = t_end_ff;
      t_job_in     = t_job_ff;
      rp_in        = rp_ff;
      lim_in       = lim_ff;
      clr_after_in = clr_after_ff;
      push         = '0;
      latch        = 1'b0;
      do_store     = 1'b0;
      req_bus.ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = !q_full;
            if (req_bus.valid && !q_full) begin
               if (!slow) begin
                  if (hdr_ff) begin
                     do_store = 1'b1;
                  end else begin
                     push.valid   = 1'b1;
                     push.op.kind = OP_FEED;
                     push.op.clr  = pend_ff;
                     push.op.last = 1'b1;
                     push.op.data = req_bus.data_byte;
                     pend_in      = 1'b0;
                  end
               end else begin
                  latch      = 1'b1;
                  t_first_in = req_bus.segment_first;
                  t_byte_in  = 1'b1;
                  t_end_in   = req_bus.segment_last | req_bus.job_last;
                  t_job_in   = req_bus.job_last;
                  state_in   = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (!q_full) begin
               if (t_first_ff) begin
                  // close any open segment, then open the header hold
                  t_first_in = 1'b0;
                  pend_in    = 1'b1;
                  if (hdr_ff && fill_ff != '0) begin
                     rp_in        = '0;
                     lim_in       = {1'b0, fill_ff};
                     clr_after_in = 1'b1;
                     state_in     = ST_REPLAY;
                  end
                  hdr_in  = 1'b1;
                  fill_in = '0;
               end else if (t_byte_ff) begin
                  t_byte_in = 1'b0;
                  if (hdr_ff) begin
                     do_store = 1'b1;
                     if (fill_top) begin
                        pend_in = 1'b1;
                        if (!m_new) begin
                           rp_in        = '0;
                           lim_in       = RP_W'(HOLD_LEN);
                           clr_after_in = 1'b0;
                           state_in     = ST_REPLAY;
                        end
                     end
                  end else begin
                     push.valid   = 1'b1;
                     push.op.kind = OP_FEED;
                     push.op.clr  = pend_ff;
                     push.op.data = it_byte_ff;
                     pend_in      = 1'b0;
                  end
               end else if (t_end_ff) begin
                  t_end_in = 1'b0;
                  pend_in  = 1'b1;
                  if (hdr_ff && fill_ff != '0) begin
                     rp_in        = '0;
                     lim_in       = {1'b0, fill_ff};
                     clr_after_in = 1'b1;
                     state_in     = ST_REPLAY;
                  end
                  hdr_in  = 1'b0;
                  fill_in = '0;
               end else if (t_job_ff) begin
                  t_job_in     = 1'b0;
                  push.valid   = 1'b1;
                  push.op.kind = OP_JOB;
                  pend_in      = 1'b0;
                  hdr_in       = 1'b0;
                  fill_in      = '0;
               end else begin
                  push.valid   = 1'b1;
                  push.op.kind = OP_END;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_REPLAY: begin
            if (!q_full) begin
               push.valid   = 1'b1;
               push.op.kind = OP_FEED;
               push.op.clr  = pend_ff;
               push.op.data = hold_ff[rp_ff[HOLD_W-1:0]];
               pend_in      = 1'b0;
               rp_in        = rp_ff + 1'b1;
               if (rp_ff + 1'b1 == lim_ff) begin
                  pend_in  = clr_after_ff;
                  state_in = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // store one header byte; the sixteenth closes the header
      if (do_store) begin
         match_in = m_new;
         if (fill_top) begin
            hdr_in  = 1'b0;
            fill_in = '0;
         end else begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hdr_ff       <= 1'b0;
         fill_ff      <= '0;
         match_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         t_first_ff   <= 1'b0;
         t_byte_ff    <= 1'b0;
         t_end_ff     <= 1'b0;
         t_job_ff     <= 1'b0;
         rp_ff        <= '0;
         lim_ff       <= '0;
         clr_after_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hdr_ff       <= hdr_in;
         fill_ff      <= fill_in;
         match_ff     <= match_in;
         pend_ff      <= pend_in;
         t_first_ff   <= t_first_in;
         t_byte_ff    <= t_byte_in;
         t_end_ff     <= t_end_in;
         t_job_ff     <= t_job_in;
         rp_ff        <= rp_in;
         lim_ff       <= lim_in;
         clr_after_ff <= clr_after_in;
      end
   end

   // Hold the beat and the header bytes
   always_ff @(posedge clock) begin
      if (latch) begin
         it_byte_ff <= req_bus.data_byte;
      end
      if (do_store) begin
         hold_ff[fill_ff] <= st_byte;
      end
   end

   `WFD_ASSERT(a_replay_bound, clock, reset, (state_ff == ST_REPLAY) |-> (rp_ff < lim_ff), "replay index past limit")

endmodule

@@ rtl/wfd_opq.sv @@
// Operation queue between the front sequencer and the parser back end.
`include "assert_macros.svh"
module wfd_opq (
   input  logic                 clock,
   input  logic                 reset,
   input  wfd_pkg::op_push_type push,
   output wfd_pkg::op_type      head,
   output logic                 head_valid,
   input  logic                 pop,
   output logic                 full
);
   import wfd_pkg::*;

   op_type            mem_ff [OPQ_DEPTH];
   logic [OPQ_AW-1:0] wr_ff, wr_in;
   logic [OPQ_AW-1:0] rd_ff, rd_in;
   logic [OPQ_AW:0]   cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   assign full       = (cnt_ff == (OPQ_AW+1)'(OPQ_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = mem_ff[rd_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers and count
   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push.op;
      end
   end

   `WFD_NEVER(a_push_full, clock, reset, push.valid && full, "op pushed into a full queue")

endmodule

@@ rtl/wfd_back.sv @@
// Parser back end: frame length, CRC32C check, field capture and result queue.
`include "assert_macros.svh"
module wfd_back (
   input  logic            clock,
   input  logic            reset,
   input  wfd_pkg::op_type op,
   input  logic            op_valid,
   output logic            op_pop,
   input  logic            csr_we,
   input  logic [63:0]     csr_wdata,
   wfd_rsp_if.source       rsp_bus
);
   import wfd_pkg::*;

   typedef struct packed {
      logic        ph;
      logic [31:0] len;
      logic [31:0] cnt;
      logic [31:0] crc;
      logic [31:0] stored;
      logic [63:0] seq;
      logic [7:0]  opf;
      logic [63:0] id;
      logic [31:0] dim;
   } parser_type;

   localparam parser_type PARSER_CLEAR = '{ph: 1'b0, len: '0, cnt: '0, crc: CRC_INIT,
                                           stored: '0, seq: '0, opf: '0, id: '0, dim: '0};

   parser_type         par_ff, par_in;
   logic [63:0]        start_ff, start_in;
   logic [63:0]        run_ff, run_in;
   logic               halt_ff, halt_in;
   logic               pres_valid_ff, pres_valid_in;
   result_type         pres_ff, pres_in;
   result_type         oq_ff [OUTQ_DEPTH];
   logic [OUTQ_AW-1:0] oq_wr_ff, oq_rd_ff;
   logic [OUTQ_AW:0]   oq_cnt_ff, oq_cnt_in;

   parser_type  pb, pn;
   logic        fin, ok, rv, is_end;
   logic        oq_full, oq_push, oq_pop;
   result_type  res_new, oq_data;
   logic [31:0] s_off, id_off, dim_off;

   assign oq_full = (oq_cnt_ff == (OUTQ_AW+1)'(OUTQ_DEPTH));
   assign op_pop  = op_valid && !oq_full;
   assign oq_pop  = rsp_bus.valid && rsp_bus.ready;

   // Feed one byte into the frame parser
   always_comb begin
      pb      = op.clr ? PARSER_CLEAR : par_ff;
      pn      = pb;
      fin     = 1'b0;
      s_off   = pb.cnt - (pb.len - 32'(CRC_LEN));
      id_off  = pb.cnt - 32'(ID_POS);
      dim_off = pb.cnt - 32'(DIM_POS);
      if (!pb.ph) begin
         pn.len[{pb.cnt[1:0], 3'b000} +: 8] = op.data;
         if (pb.cnt[1:0] == 2'd3) begin
            pn.cnt = '0;
            pn.ph  = 1'b1;
            fin    = (pn.len == '0);
         end else begin
            pn.cnt = pb.cnt + 32'd1;
         end
      end else begin
         if (pb.len >= 32'(CRC_LEN)) begin
            if (pb.cnt < pb.len - 32'(CRC_LEN)) begin
               pn.crc = crc32c_byte(pb.crc, op.data);
            end else begin
               pn.stored[{s_off[1:0], 3'b000} +: 8] = op.data;
            end
         end
         if (pb.cnt < 32'(SEQ_BYTES)) begin
            pn.seq[{pb.cnt[2:0], 3'b000} +: 8] = op.data;
         end else if (pb.cnt == 32'(OP_POS)) begin
            pn.opf = op.data;
         end else if (pb.cnt < 32'(DIM_POS)) begin
            pn.id[{id_off[2:0], 3'b000} +: 8] = op.data;
         end else if (pb.cnt < 32'(PREFIX_LEN)) begin
            pn.dim[{dim_off[1:0], 3'b000} +: 8] = op.data;
         end
         pn.cnt = pb.cnt + 32'd1;
         fin    = (pn.cnt >= pb.len);
      end
      ok = (pn.len >= 32'(MIN_BODY)) && ((pn.crc ^ CRC_INIT) == pn.stored);
   end

   // Carry out the op and stage its result
   always_comb begin
      par_in        = par_ff;
      start_in      = start_ff;
      run_in        = run_ff;
      halt_in       = halt_ff;
      pres_valid_in = pres_valid_ff;
      pres_in       = pres_ff;
      rv            = 1'b0;
      res_new       = '0;
      oq_push       = 1'b0;
      oq_data       = pres_ff;
      is_end        = op_pop && ((op.kind == OP_END) || ((op.kind == OP_FEED) && op.last));

      if (op_pop) begin
         case (op.kind)
            OP_FEED: begin
               if (!halt_ff) begin
                  if (fin) begin
                     par_in = PARSER_CLEAR;
                     if (!ok) begin
                        rv           = 1'b1;
                        res_new.kind = KIND_CORRUPT;
                        res_new.seq  = run_ff;
                        halt_in      = 1'b1;
                     end else if (pn.seq > run_ff) begin
                        rv             = 1'b1;
                        res_new.kind   = KIND_RECORD;
                        res_new.seq    = pn.seq;
                        res_new.rec_op = pn.opf;
                        res_new.id     = pn.id;
                        res_new.dim    = pn.dim;
                        res_new.pay    = pn.len - 32'(MIN_BODY);
                        run_in         = pn.seq;
                     end
                  end else begin
                     par_in = pn;
                  end
               end
            end
            OP_JOB: begin
               if (!halt_ff) begin
                  rv           = 1'b1;
                  res_new.kind = KIND_DONE;
                  res_new.seq  = run_ff;
               end
               halt_in = 1'b0;
               run_in  = start_ff;
               par_in  = PARSER_CLEAR;
            end
            default: begin
            end
         endcase
      end

      // hold one result back until the beat's end decides its last flag
      if (rv) begin
         if (is_end) begin
            oq_push      = 1'b1;
            oq_data      = res_new;
            oq_data.last = 1'b1;
         end else begin
            if (pres_valid_ff) begin
               oq_push      = 1'b1;
               oq_data      = pres_ff;
               oq_data.last = 1'b0;
            end
            pres_valid_in = 1'b1;
            pres_in       = res_new;
         end
      end else if (is_end && pres_valid_ff) begin
         oq_push       = 1'b1;
         oq_data       = pres_ff;
         oq_data.last  = 1'b1;
         pres_valid_in = 1'b0;
      end

      if (csr_we) begin
         start_in = csr_wdata;
         run_in   = csr_wdata;
      end

      oq_cnt_in = oq_cnt_ff;
      if (oq_push && !oq_pop) begin
         oq_cnt_in = oq_cnt_ff + 1'b1;
      end else if (!oq_push && oq_pop) begin
         oq_cnt_in = oq_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         par_ff        <= PARSER_CLEAR;
         start_ff      <= '0;
         run_ff        <= '0;
         halt_ff       <= 1'b0;
         pres_valid_ff <= 1'b0;
         oq_wr_ff      <= '0;
         oq_rd_ff      <= '0;
         oq_cnt_ff     <= '0;
      end else begin
         par_ff        <= par_in;
         start_ff      <= start_in;
         run_ff        <= run_in;
         halt_ff       <= halt_in;
         pres_valid_ff <= pres_valid_in;
         oq_cnt_ff     <= oq_cnt_in;
         if (oq_push) begin
            oq_wr_ff <= oq_wr_ff + 1'b1;
         end
         if (oq_pop) begin
            oq_rd_ff <= oq_rd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      pres_ff <= pres_in;
      if (oq_push) begin
         oq_ff[oq_wr_ff] <= oq_data;
      end
   end

   // Drive the result channel from the queue head
   assign rsp_bus.valid         = (oq_cnt_ff != '0);
   assign rsp_bus.kind          = oq_ff[oq_rd_ff].kind;
   assign rsp_bus.sequence_res  = oq_ff[oq_rd_ff].seq;
   assign rsp_bus.record_op     = oq_ff[oq_rd_ff].rec_op;
   assign rsp_bus.record_id     = oq_ff[oq_rd_ff].id;
   assign rsp_bus.dimension     = oq_ff[oq_rd_ff].dim;
   assign rsp_bus.payload_bytes = oq_ff[oq_rd_ff].pay;
   assign rsp_bus.last          = oq_ff[oq_rd_ff].last;

   `WFD_NEVER(a_oq_over, clock, reset, oq_push && oq_full, "result queue overflow")
   `WFD_ASSERT(a_flush, clock, reset, is_end |=> !pres_valid_ff, "result held past beat end")

endmodule
